/* rtl/java_escape_unescaper_core_assert.svh */
// assertion macros for the java escape unescaper checker
// no dependencies; included by the checker file
`ifndef JAVA_ESCAPE_UNESCAPER_CORE_ASSERT_SVH
`define JAVA_ESCAPE_UNESCAPER_CORE_ASSERT_SVH

// same-cycle implication, masked while reset is held
`define JEU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("jeu check failed");

// next-cycle implication, masked while reset is held
`define JEU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("jeu check failed");

// next-cycle implication that also runs through reset
`define JEU_ASSERT_NXT_ALL(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("jeu check failed");

`endif

/* rtl/jeu_pkg.sv */
// shared types, character codes and helpers for the java escape unescaper
// no dependencies
`timescale 1ns / 1ps

package jeu_pkg;

  // decoder mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_t;

  localparam int MaxRes = 6;
  localparam int ResIdxW = $clog2(MaxRes);

  // character codes
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_U      = 16'h0075;
  localparam logic [15:0] CH_B      = 16'h0062;
  localparam logic [15:0] CH_T      = 16'h0074;
  localparam logic [15:0] CH_N      = 16'h006E;
  localparam logic [15:0] CH_F      = 16'h0066;
  localparam logic [15:0] CH_R      = 16'h0072;
  localparam logic [15:0] CH_DQUOTE = 16'h0022;
  localparam logic [15:0] CH_SQUOTE = 16'h0027;
  localparam logic [15:0] CTL_BS    = 16'h0008;
  localparam logic [15:0] CTL_TAB   = 16'h0009;
  localparam logic [15:0] CTL_LF    = 16'h000A;
  localparam logic [15:0] CTL_FF    = 16'h000C;
  localparam logic [15:0] CTL_CR    = 16'h000D;

  // ascii hex digit decode: bit 4 set when valid, low nibble holds value
  function automatic logic [4:0] hex_digit(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // ascii octal digit test
  function automatic logic is_oct(input logic [15:0] c);
    return c[15:3] == 13'h0006;
  endfunction

endpackage

/* rtl/java_escape_unescaper_core.sv */
// java escape unescaper: decodes backslash escapes in a stream of utf-16 code units
// depends on jeu_pkg
`timescale 1ns / 1ps
//
// channel  | direction | tdata          | tlast       | tuser
// in_      | slave     | [15:0] char_in | string_end  | -
// out_     | master    | [15:0] char_out| run_last    | text_last
//
// one item is decoded in the cycle it is accepted; its results land in a six-entry
// result register and leave one per cycle while the output is ready.
// an item with zero or one result keeps the input at one item per cycle while the
// output is ready; the result register drains one result a cycle while it is ready.
// a new item is taken in the cycle the last result of the previous one is taken.
// synchronous active-low reset clears mode, digit count/value, result count and read index.

module java_escape_unescaper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] char_in
  input  logic        in_tlast,   // string_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] char_out
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // [0] text_last
);
  import jeu_pkg::*;

  localparam int CntW = $clog2(MaxRes + 1);

  // decoder state
  mode_t          mode_r, mode_nxt;
  logic [1:0]     dcnt_r, dcnt_nxt;
  logic [11:0]    dval_r, dval_nxt;
  logic [6:0]     held_r [3];
  logic [6:0]     held_nxt [3];

  // result register
  logic [15:0]        res_r [MaxRes];
  logic [15:0]        res_nxt [MaxRes];
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [ResIdxW-1:0] idx_r;
  logic               end_r;

  logic [CntW-1:0] n;
  logic [4:0]      hv;
  logic            redo;
  logic            in_fire, out_fire, at_last;
  logic [15:0]     c;

  assign c        = in_tdata;
  assign hv       = hex_digit(c);
  assign at_last  = (CntW'(idx_r) == cnt_r - CntW'(1));
  assign in_tready = (cnt_r == '0) || (at_last && out_tready);
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // decode one item into a list of results and the next decoder state
  always_comb begin
    mode_nxt = mode_r;
    dcnt_nxt = dcnt_r;
    dval_nxt = dval_r;
    held_nxt = held_r;
    for (int k = 0; k < MaxRes; k++) res_nxt[k] = 16'd0;
    n    = '0;
    redo = 1'b0;
    case (mode_r)
      MODE_IDLE: begin
        redo = 1'b1;
      end
      MODE_ESC: begin
        mode_nxt = MODE_IDLE;
        case (c)
          CH_B:      begin res_nxt[0] = CTL_BS;  n = CntW'(1); end
          CH_T:      begin res_nxt[0] = CTL_TAB; n = CntW'(1); end
          CH_N:      begin res_nxt[0] = CTL_LF;  n = CntW'(1); end
          CH_F:      begin res_nxt[0] = CTL_FF;  n = CntW'(1); end
          CH_R:      begin res_nxt[0] = CTL_CR;  n = CntW'(1); end
          CH_DQUOTE, CH_SQUOTE, CH_BSLASH: begin
            res_nxt[0] = c;
            n = CntW'(1);
          end
          CH_U: begin
            mode_nxt = MODE_HEX;
            dcnt_nxt = 2'd0;
            dval_nxt = 12'd0;
          end
          default: begin
            if (is_oct(c)) begin
              mode_nxt = MODE_OCT;
              dcnt_nxt = 2'd1;
              dval_nxt = {9'd0, c[2:0]};
            end else begin
              res_nxt[0] = CH_BSLASH;
              res_nxt[1] = c;
              n = CntW'(2);
            end
          end
        endcase
      end
      MODE_HEX: begin
        if (hv[4]) begin
          if (dcnt_r == 2'd3) begin
            res_nxt[0] = {dval_r, hv[3:0]};
            n = CntW'(1);
            mode_nxt = MODE_IDLE;
            dcnt_nxt = 2'd0;
            dval_nxt = 12'd0;
          end else begin
            held_nxt[dcnt_r] = c[6:0];
            dval_nxt = {dval_r[7:0], hv[3:0]};
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end else begin
          // broken unicode run: replay it raw, then decode the breaking unit
          res_nxt[0] = CH_BSLASH;
          res_nxt[1] = CH_U;
          n = CntW'(2);
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < dcnt_r) begin
              res_nxt[n[ResIdxW-1:0]] = {9'd0, held_r[k]};
              n = n + CntW'(1);
            end
          end
          mode_nxt = MODE_IDLE;
          dcnt_nxt = 2'd0;
          dval_nxt = 12'd0;
          redo = 1'b1;
        end
      end
      MODE_OCT: begin
        if (is_oct(c)) begin
          if (dcnt_r == 2'd2) begin
            res_nxt[0] = {4'd0, dval_r[8:0], c[2:0]};
            n = CntW'(1);
            mode_nxt = MODE_IDLE;
            dcnt_nxt = 2'd0;
            dval_nxt = 12'd0;
          end else begin
            dval_nxt = {dval_r[8:0], c[2:0]};
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end else begin
          res_nxt[0] = {4'd0, dval_r};
          n = CntW'(1);
          mode_nxt = MODE_IDLE;
          dcnt_nxt = 2'd0;
          dval_nxt = 12'd0;
          redo = 1'b1;
        end
      end
      default: ;
    endcase

    // unit taken as if no escape were pending
    if (redo) begin
      if (c == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        res_nxt[n[ResIdxW-1:0]] = c;
        n = n + CntW'(1);
      end
    end

    // end of string flushes whatever escape is still open
    if (in_tlast) begin
      case (mode_nxt)
        MODE_ESC: begin
          res_nxt[n[ResIdxW-1:0]] = CH_BSLASH;
          n = n + CntW'(1);
        end
        MODE_HEX: begin
          res_nxt[n[ResIdxW-1:0]] = CH_BSLASH;
          n = n + CntW'(1);
          res_nxt[n[ResIdxW-1:0]] = CH_U;
          n = n + CntW'(1);
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < dcnt_nxt) begin
              res_nxt[n[ResIdxW-1:0]] = {9'd0, held_nxt[k]};
              n = n + CntW'(1);
            end
          end
        end
        MODE_OCT: begin
          res_nxt[n[ResIdxW-1:0]] = {4'd0, dval_nxt};
          n = n + CntW'(1);
        end
        default: ;
      endcase
      mode_nxt = MODE_IDLE;
      dcnt_nxt = 2'd0;
      dval_nxt = 12'd0;
    end
  end

  // next result count
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = n;
    end else if (out_fire && at_last) begin
      cnt_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dcnt_r <= 2'd0;
      dval_r <= 12'd0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        mode_r <= mode_nxt;
        dcnt_r <= dcnt_nxt;
        dval_r <= dval_nxt;
        idx_r  <= '0;
      end else if (out_fire && !at_last) begin
        idx_r <= idx_r + ResIdxW'(1);
      end
    end
  end

  // payload: held digits, results and end flag
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r <= held_nxt;
      res_r  <= res_nxt;
      end_r  <= in_tlast;
    end
  end

  // output port
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = res_r[idx_r];
  assign out_tlast  = at_last;
  assign out_tuser  = at_last && end_r;

endmodule

/* rtl/jeu_checker.sv */
// port-level checks for the java escape unescaper, bound to the top level
// depends on java_escape_unescaper_core_assert.svh
`timescale 1ns / 1ps
`include "java_escape_unescaper_core_assert.svh"

module jeu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // string end flag only rides on the last result of an item
  `JEU_ASSERT_IMP(a_user_on_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)

  // no new item while earlier results of the current one are still queued
  `JEU_ASSERT_IMP(a_no_take_mid_run, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  // a stalled result holds its value
  `JEU_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // reset empties the result register
  `JEU_ASSERT_NXT_ALL(a_reset_empty, clk, !rst_n, !out_tvalid)

endmodule

bind java_escape_unescaper_core jeu_checker u_jeu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
